[hw/rtl/dbrc_pkg.sv]
package dbrc_pkg;

  localparam int unsigned TimeW   = 64;
  localparam int unsigned MinW    = 30;
  localparam int unsigned RatioW  = 24;
  localparam int unsigned RateW   = 22;
  localparam int unsigned PktW    = 17;
  localparam int unsigned GapW    = 15;
  localparam int unsigned FrameW  = 32;
  localparam int unsigned WinW    = 40;
  localparam int unsigned PeriodW = 30;
  localparam int unsigned PayW    = 16;
  localparam int unsigned CfgAW   = 3;
  localparam int unsigned CfgDW   = 40;

  // divider operand widths
  localparam int unsigned DivRW = 30;
  localparam int unsigned DivSW = 24;
  localparam int unsigned DivCW = 5;

  localparam logic [MinW-1:0]   SentinelNs = 30'd1000000000;
  localparam logic [RatioW-1:0] RatioMax   = 24'd16777215;
  localparam logic [RatioW-1:0] ThLow      = 24'd55705;
  localparam logic [RatioW-1:0] ThOne      = 24'd65536;
  localparam logic [16:0]       MulUp      = 17'd68813;
  localparam logic [16:0]       MulDown    = 17'd45875;
  localparam logic [RateW:0]    AddStep    = 23'd6554;
  localparam logic [14:0]       BytesMul   = 15'd16660;
  localparam logic [22:0]       GapMul     = 23'd6666664;
  localparam logic [8:0]        GapDiv     = 9'd500;
  localparam logic [RateW-1:0]  RateReset  = 22'd655360;

  localparam logic [WinW-1:0]    WinReset    = 40'd10000000000;
  localparam logic [PeriodW-1:0] PeriodReset = 30'd16666666;
  localparam logic [PayW-1:0]    PayReset    = 16'd1200;
  localparam logic [RateW-1:0]   CeilReset   = 22'd3276800;
  localparam logic [RateW-1:0]   FloorReset  = 22'd65536;

  typedef enum logic [CfgAW-1:0] {
    CFG_EXPIRY  = 3'd0,
    CFG_PERIOD  = 3'd1,
    CFG_PAYLOAD = 3'd2,
    CFG_CEIL    = 3'd3,
    CFG_FLOOR   = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_NONE,
    ST_FB_EXP,
    ST_FB_MIN,
    ST_FB_DIFF,
    ST_FB_DIV,
    ST_TK_MUL,
    ST_TK_CLAMP,
    ST_TK_BYTES,
    ST_TK_PDIV,
    ST_TK_PSAT,
    ST_TK_GMUL,
    ST_TK_GDIV,
    ST_OUT
  } dp_step_t;

  typedef struct packed {
    logic     ld_in;
    dp_step_t step;
  } dp_cmd_t;

  typedef struct packed {
    logic op_tick;
    logic div_busy;
  } dp_sts_t;

endpackage

[hw/rtl/delay_based_rate_controller_core.sv]
// Channel  Direction  Handshake            Payload
// in_      slave      in_tvalid/in_tready   tdata: sent_time, recv_time, time_now; tuser: op
// out_     master     out_tvalid/out_tready tdata: util_ratio .. frame_number
// cfg_     slave      cfg_valid/cfg_ready   cfg_addr register index, cfg_data value
//
// One transaction at a time. A feedback passes through the shared bit-serial divider, which
// is skipped when the ratio saturates; a frame tick uses it twice. The divider runs
// 24 steps for the ratio, 18 for packets and 23 for the gap.
// rst_n is synchronous; no clearing pass.
// A finished result sits in the output register while the next transaction is taken;
// the result step waits only if that register is still full.
module delay_based_rate_controller_core
  import dbrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [191:0]       in_tdata,   // sent_time[63:0], recv_time, time_now
  input  logic               in_tuser,   // op
  output logic               out_tvalid,
  input  logic               out_tready,
  // util_ratio[23:0], min_delay[53:24], send_rate[75:54], packets_per_frame[92:76],
  // pacing_gap_us[107:93], frame_number[139:108], zero pad
  output logic [143:0]       out_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgAW-1:0]   cfg_addr,
  input  logic [CfgDW-1:0]   cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  logic [RatioW-1:0] o_util;
  logic [MinW-1:0]   o_min;
  logic [RateW-1:0]  o_rate;
  logic [PktW-1:0]   o_pkts;
  logic [GapW-1:0]   o_gap;
  logic [FrameW-1:0] o_frame;

  assign cfg_ready = 1'b1;

  dbrc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dbrc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_op    (in_tuser),
    .in_sent  (in_tdata[63:0]),
    .in_recv  (in_tdata[127:64]),
    .in_now   (in_tdata[191:128]),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .o_util   (o_util),
    .o_min    (o_min),
    .o_rate   (o_rate),
    .o_pkts   (o_pkts),
    .o_gap    (o_gap),
    .o_frame  (o_frame)
  );

  assign out_tdata = {4'd0, o_frame, o_gap, o_pkts, o_rate, o_min, o_util};

endmodule

[hw/rtl/dbrc_div.sv]
module dbrc_div
  import dbrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DivRW-1:0] rem_init,
  input  logic [DivSW-1:0] shift_in,
  input  logic [DivCW-1:0] steps,
  input  logic [DivRW-1:0] divisor,
  output logic             busy,
  output logic [DivSW-1:0] quot
);

  logic             busy_r, busy_nxt;
  logic [DivCW-1:0] cnt_r, cnt_nxt;
  logic [DivRW-1:0] rem_r, rem_nxt;
  logic [DivSW-1:0] sh_r, sh_nxt;
  logic [DivSW-1:0] q_r, q_nxt;
  logic [DivRW-1:0] dvs_r, dvs_nxt;
  logic [DivRW:0]   trial;
  logic             fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, sh_r[DivSW-1]};
    fits     = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      rem_nxt  = rem_init;
      sh_nxt   = shift_in;
      q_nxt    = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? DivRW'(trial - {1'b0, dvs_r}) : trial[DivRW-1:0];
      sh_nxt   = {sh_r[DivSW-2:0], 1'b0};
      q_nxt    = {q_r[DivSW-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != DivCW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

[hw/rtl/dbrc_dp.sv]
module dbrc_dp
  import dbrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic               in_op,
  input  logic [TimeW-1:0]   in_sent,
  input  logic [TimeW-1:0]   in_recv,
  input  logic [TimeW-1:0]   in_now,
  input  logic               cfg_we,
  input  logic [CfgAW-1:0]   cfg_addr,
  input  logic [CfgDW-1:0]   cfg_data,
  output logic [RatioW-1:0]  o_util,
  output logic [MinW-1:0]    o_min,
  output logic [RateW-1:0]   o_rate,
  output logic [PktW-1:0]    o_pkts,
  output logic [GapW-1:0]    o_gap,
  output logic [FrameW-1:0]  o_frame
);

  logic [WinW-1:0]    win_r;
  logic [PeriodW-1:0] period_r;
  logic [PayW-1:0]    pay_r;
  logic [RateW-1:0]   ceil_r, floor_r;

  logic [MinW-1:0]   min_r;
  logic [TimeW-1:0]  upd_r;
  logic [RatioW-1:0] ratio_r;
  logic [RateW-1:0]  rate_r;
  logic [FrameW-1:0] frame_r;

  logic              op_r;
  logic [TimeW-1:0]  delay_r, now_r, diff_r;
  logic              sat_r;
  logic [RateW:0]    rnew_r;
  logic [17:0]       bytes_r;
  logic [PktW-1:0]   pkts_r;
  logic [22:0]       num_r;
  logic [25:0]       dg_r;

  logic [PeriodW-1:0] period_eff;
  logic [PayW-1:0]    pay_eff;
  logic               sat;
  logic [38:0]        rprod;
  logic [RateW:0]     clamp_a;
  logic [RateW-1:0]   clamp_b;
  logic [36:0]        bprod;
  logic [16:0]        rmin;
  logic [39:0]        nprod;
  logic [RatioW-1:0]  ratio_v;

  logic             div_start;
  logic [DivRW-1:0] div_rem0;
  logic [DivSW-1:0] div_sh;
  logic [DivCW-1:0] div_steps;
  logic [DivRW-1:0] div_dvs;
  logic             div_busy;
  logic [DivSW-1:0] div_q;

  assign period_eff = (period_r == '0) ? PeriodW'(1) : period_r;
  assign pay_eff    = (pay_r == '0) ? PayW'(1) : pay_r;
  assign sat        = diff_r >= {26'd0, period_eff, 8'd0};

  always_comb begin
    if (ratio_r <= ThLow) begin
      rprod = {17'd0, rate_r} * {22'd0, MulUp};
    end else begin
      rprod = {17'd0, rate_r} * {22'd0, MulDown};
    end
  end

  assign clamp_a = (rnew_r > {1'b0, ceil_r}) ? {1'b0, ceil_r} : rnew_r;
  assign clamp_b = (clamp_a < {1'b0, floor_r}) ? floor_r : clamp_a[RateW-1:0];
  assign bprod   = {15'd0, rate_r} * {22'd0, BytesMul};
  assign rmin    = (ratio_r < ThOne) ? ratio_r[16:0] : ThOne[16:0];
  assign nprod   = {23'd0, rmin} * {17'd0, GapMul};
  assign ratio_v = sat_r ? RatioMax : div_q;

  always_comb begin
    div_start = 1'b0;
    div_rem0  = '0;
    div_sh    = '0;
    div_steps = '0;
    div_dvs   = '0;
    case (cmd.step)
      ST_FB_DIV: begin
        div_start = !sat;
        div_rem0  = diff_r[37:8];
        div_sh    = {diff_r[7:0], 16'd0};
        div_steps = DivCW'(24);
        div_dvs   = period_eff;
      end
      ST_TK_PDIV: begin
        div_start = 1'b1;
        div_sh    = {bytes_r, 6'd0};
        div_steps = DivCW'(18);
        div_dvs   = {14'd0, pay_eff};
      end
      ST_TK_GDIV: begin
        div_start = 1'b1;
        div_sh    = {num_r, 1'b0};
        div_steps = DivCW'(23);
        div_dvs   = {4'd0, dg_r};
      end
      default: begin
      end
    endcase
  end

  dbrc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem0),
    .shift_in (div_sh),
    .steps    (div_steps),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quot     (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= WinReset;
      period_r <= PeriodReset;
      pay_r    <= PayReset;
      ceil_r   <= CeilReset;
      floor_r  <= FloorReset;
      min_r    <= SentinelNs;
      upd_r    <= '0;
      ratio_r  <= '0;
      rate_r   <= RateReset;
      frame_r  <= '0;
      op_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_EXPIRY:  win_r    <= cfg_data[WinW-1:0];
          CFG_PERIOD:  period_r <= cfg_data[PeriodW-1:0];
          CFG_PAYLOAD: pay_r    <= cfg_data[PayW-1:0];
          CFG_CEIL:    ceil_r   <= cfg_data[RateW-1:0];
          CFG_FLOOR:   floor_r  <= cfg_data[RateW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.ld_in) begin
        op_r <= in_op;
      end
      case (cmd.step)
        ST_FB_EXP: begin
          if ((now_r - upd_r) > {24'd0, win_r}) begin
            min_r <= SentinelNs;
          end
        end
        ST_FB_MIN: begin
          if (delay_r < {34'd0, min_r}) begin
            min_r <= delay_r[MinW-1:0];
            upd_r <= now_r;
          end
        end
        ST_TK_CLAMP: rate_r <= clamp_b;
        ST_OUT: begin
          if (op_r) begin
            frame_r <= frame_r + 1'b1;
          end else begin
            ratio_r <= ratio_v;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      delay_r <= in_recv - in_sent;
      now_r   <= in_now;
    end
    case (cmd.step)
      ST_FB_DIFF: diff_r <= delay_r - {34'd0, min_r};
      ST_FB_DIV:  sat_r  <= sat;
      ST_TK_MUL: begin
        if (ratio_r > ThLow && ratio_r <= ThOne) begin
          rnew_r <= {1'b0, rate_r} + AddStep;
        end else begin
          rnew_r <= rprod[38:16];
        end
      end
      ST_TK_BYTES: bytes_r <= bprod[36:19];
      ST_TK_PSAT: begin
        if (div_q[17]) begin
          pkts_r <= '1;
        end else if (div_q[16:0] == '0) begin
          pkts_r <= PktW'(1);
        end else begin
          pkts_r <= div_q[16:0];
        end
        num_r <= nprod[38:16];
      end
      ST_TK_GMUL: dg_r <= {9'd0, pkts_r} * {17'd0, GapDiv};
      ST_OUT: begin
        o_min  <= min_r;
        o_rate <= rate_r;
        if (op_r) begin
          o_util  <= ratio_r;
          o_pkts  <= pkts_r;
          o_gap   <= div_q[GapW-1:0];
          o_frame <= frame_r;
        end else begin
          o_util  <= ratio_v;
          o_pkts  <= '0;
          o_gap   <= '0;
          o_frame <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts.op_tick  = op_r;
  assign sts.div_busy = div_busy;

endmodule

[hw/rtl/dbrc_ctrl.sv]
module dbrc_ctrl
  import dbrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_FB_EXP, S_FB_MIN, S_FB_DIFF, S_FB_DIV, S_FB_WAIT,
    S_TK_MUL, S_TK_CLAMP, S_TK_BYTES, S_TK_PDIV, S_TK_PWAIT, S_TK_PSAT,
    S_TK_GMUL, S_TK_GDIV, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.ld_in     = 1'b0;
    cmd.step      = ST_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: state_nxt = sts.op_tick ? S_TK_MUL : S_FB_EXP;
      S_FB_EXP: begin
        cmd.step  = ST_FB_EXP;
        state_nxt = S_FB_MIN;
      end
      S_FB_MIN: begin
        cmd.step  = ST_FB_MIN;
        state_nxt = S_FB_DIFF;
      end
      S_FB_DIFF: begin
        cmd.step  = ST_FB_DIFF;
        state_nxt = S_FB_DIV;
      end
      S_FB_DIV: begin
        cmd.step  = ST_FB_DIV;
        state_nxt = S_FB_WAIT;
      end
      S_FB_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_TK_MUL: begin
        cmd.step  = ST_TK_MUL;
        state_nxt = S_TK_CLAMP;
      end
      S_TK_CLAMP: begin
        cmd.step  = ST_TK_CLAMP;
        state_nxt = S_TK_BYTES;
      end
      S_TK_BYTES: begin
        cmd.step  = ST_TK_BYTES;
        state_nxt = S_TK_PDIV;
      end
      S_TK_PDIV: begin
        cmd.step  = ST_TK_PDIV;
        state_nxt = S_TK_PWAIT;
      end
      S_TK_PWAIT: begin
        if (!sts.div_busy) begin
          state_nxt = S_TK_PSAT;
        end
      end
      S_TK_PSAT: begin
        cmd.step  = ST_TK_PSAT;
        state_nxt = S_TK_GMUL;
      end
      S_TK_GMUL: begin
        cmd.step  = ST_TK_GMUL;
        state_nxt = S_TK_GDIV;
      end
      S_TK_GDIV: begin
        cmd.step  = ST_TK_GDIV;
        state_nxt = S_FB_WAIT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.step      = ST_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
